[src/jfcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfcs_pkg
// Shared types, register codes and the step program of the JTAG configuration
// sequencer.
// ----------------------------------------------------------------------------
package jfcs_pkg;

  // Width of the instruction registers held in configuration
  localparam int REG_BITS   = 10;
  localparam int CNT_W      = 13;
  localparam int RST_W      = 8;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int PC_W       = 6;
  localparam int IDX_W      = 4;
  localparam int Q_DEPTH    = 2;
  localparam int QPTR_W     = $clog2(Q_DEPTH);
  localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

  // Item kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_POST  = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_PROGRAM_INSTR  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STATUS_INSTR   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STARTUP_INSTR  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PRELOAD_CLOCKS = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_IDLE_CLOCKS    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_POSTAMBLE_ONES = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RESET_CLOCKS   = 3'd6;

  // Register reset values
  localparam logic [REG_BITS-1:0] RST_PROGRAM_INSTR  = 10'd2;
  localparam logic [REG_BITS-1:0] RST_STATUS_INSTR   = 10'd4;
  localparam logic [REG_BITS-1:0] RST_STARTUP_INSTR  = 10'd3;
  localparam logic [CNT_W-1:0]    RST_PRELOAD_CLOCKS = 13'd5000;
  localparam logic [CNT_W-1:0]    RST_IDLE_CLOCKS    = 13'd200;
  localparam logic [CNT_W-1:0]    RST_POSTAMBLE_ONES = 13'd127;
  localparam logic [RST_W-1:0]    RST_RESET_CLOCKS   = 8'd10;

  // Step operation codes
  localparam logic [3:0] OP_PULSE         = 4'd0; // one pulse, held TDI
  localparam logic [3:0] OP_PULSE_HI      = 4'd1; // one pulse, TDI driven high
  localparam logic [3:0] OP_SHIFT         = 4'd2; // shift an instruction
  localparam logic [3:0] OP_DATA          = 4'd3; // shift the data byte
  localparam logic [3:0] OP_RUN_RESET     = 4'd4;
  localparam logic [3:0] OP_RUN_RESET_REL = 4'd5;
  localparam logic [3:0] OP_RUN_PRELOAD   = 4'd6;
  localparam logic [3:0] OP_RUN_ONES      = 4'd7;
  localparam logic [3:0] OP_RUN_IDLE      = 4'd8;

  // Instruction select
  localparam logic [1:0] SEL_PROGRAM = 2'd0;
  localparam logic [1:0] SEL_STATUS  = 2'd1;
  localparam logic [1:0] SEL_STARTUP = 2'd2;

  // Program entry points
  localparam logic [PC_W-1:0] PC_START = 6'd0;
  localparam logic [PC_W-1:0] PC_DATA  = 6'd12;
  localparam logic [PC_W-1:0] PC_POST  = 6'd13;
  localparam logic [PC_W-1:0] PC_END   = 6'd15;

  typedef struct packed {
    logic [3:0] code;
    logic       tms;
    logic [1:0] sel;
    logic       last;
  } op_t;

  typedef struct packed {
    logic [PC_W-1:0] pc;
    logic [7:0]      data_byte;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

  typedef struct packed {
    logic [REG_BITS-1:0] program_instr;
    logic [REG_BITS-1:0] status_instr;
    logic [REG_BITS-1:0] startup_instr;
    logic [CNT_W-1:0]    preload_clocks;
    logic [CNT_W-1:0]    idle_clocks;
    logic [CNT_W-1:0]    postamble_ones;
    logic [RST_W-1:0]    reset_clocks;
  } cfg_t;

  function automatic op_t mk_op(input logic [3:0] code, input logic tms,
                                input logic [1:0] sel, input logic last);
    op_t o;
    o.code = code;
    o.tms  = tms;
    o.sel  = sel;
    o.last = last;
    return o;
  endfunction

  function automatic logic [PC_W-1:0] start_pc(input logic [1:0] kind);
    logic [PC_W-1:0] pc;
    case (kind)
      KIND_START: pc = PC_START;
      KIND_DATA:  pc = PC_DATA;
      KIND_POST:  pc = PC_POST;
      default:    pc = PC_END;
    endcase
    return pc;
  endfunction

  // Step program: each entry yields one result, or a short series for
  // instruction and data shifts.
  function automatic op_t rom_op(input logic [PC_W-1:0] pc);
    op_t o;
    case (pc)
      // start
      6'd0:  o = mk_op(OP_RUN_RESET,     1'b1, SEL_PROGRAM, 1'b0);
      6'd1:  o = mk_op(OP_PULSE,         1'b0, SEL_PROGRAM, 1'b0);
      6'd2:  o = mk_op(OP_PULSE,         1'b1, SEL_PROGRAM, 1'b0);
      6'd3:  o = mk_op(OP_PULSE,         1'b1, SEL_PROGRAM, 1'b0);
      6'd4:  o = mk_op(OP_PULSE,         1'b0, SEL_PROGRAM, 1'b0);
      6'd5:  o = mk_op(OP_PULSE,         1'b0, SEL_PROGRAM, 1'b0);
      6'd6:  o = mk_op(OP_SHIFT,         1'b0, SEL_PROGRAM, 1'b0);
      6'd7:  o = mk_op(OP_PULSE,         1'b1, SEL_PROGRAM, 1'b0);
      6'd8:  o = mk_op(OP_PULSE_HI,      1'b1, SEL_PROGRAM, 1'b0);
      6'd9:  o = mk_op(OP_PULSE,         1'b0, SEL_PROGRAM, 1'b0);
      6'd10: o = mk_op(OP_PULSE,         1'b0, SEL_PROGRAM, 1'b0);
      6'd11: o = mk_op(OP_RUN_PRELOAD,   1'b0, SEL_PROGRAM, 1'b1);
      // data byte
      6'd12: o = mk_op(OP_DATA,          1'b0, SEL_PROGRAM, 1'b1);
      // postamble
      6'd13: o = mk_op(OP_RUN_ONES,      1'b0, SEL_PROGRAM, 1'b0);
      6'd14: o = mk_op(OP_PULSE,         1'b1, SEL_PROGRAM, 1'b1);
      // end
      6'd15: o = mk_op(OP_PULSE,         1'b1, SEL_STATUS,  1'b0);
      6'd16: o = mk_op(OP_PULSE,         1'b0, SEL_STATUS,  1'b0);
      6'd17: o = mk_op(OP_PULSE,         1'b0, SEL_STATUS,  1'b0);
      6'd18: o = mk_op(OP_PULSE,         1'b1, SEL_STATUS,  1'b0);
      6'd19: o = mk_op(OP_PULSE,         1'b1, SEL_STATUS,  1'b0);
      6'd20: o = mk_op(OP_PULSE,         1'b0, SEL_STATUS,  1'b0);
      6'd21: o = mk_op(OP_PULSE,         1'b0, SEL_STATUS,  1'b0);
      6'd22: o = mk_op(OP_SHIFT,         1'b0, SEL_STATUS,  1'b0);
      6'd23: o = mk_op(OP_PULSE,         1'b1, SEL_STARTUP, 1'b0);
      6'd24: o = mk_op(OP_PULSE,         1'b1, SEL_STARTUP, 1'b0);
      6'd25: o = mk_op(OP_PULSE,         1'b1, SEL_STARTUP, 1'b0);
      6'd26: o = mk_op(OP_PULSE,         1'b0, SEL_STARTUP, 1'b0);
      6'd27: o = mk_op(OP_PULSE,         1'b0, SEL_STARTUP, 1'b0);
      6'd28: o = mk_op(OP_SHIFT,         1'b0, SEL_STARTUP, 1'b0);
      6'd29: o = mk_op(OP_PULSE,         1'b1, SEL_STARTUP, 1'b0);
      6'd30: o = mk_op(OP_PULSE,         1'b0, SEL_STARTUP, 1'b0);
      6'd31: o = mk_op(OP_RUN_IDLE,      1'b0, SEL_STARTUP, 1'b0);
      6'd32: o = mk_op(OP_RUN_RESET_REL, 1'b1, SEL_STARTUP, 1'b1);
      default: o = mk_op(OP_PULSE,       1'b0, SEL_PROGRAM, 1'b1);
    endcase
    return o;
  endfunction

endpackage

[src/jfcs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfcs_front
// Accepts script items, maps each kind to its program entry point and holds
// them in a short queue for the step engine.
// ----------------------------------------------------------------------------
module jfcs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          kind,
  input  logic [7:0]          data_byte,
  output jfcs_pkg::qhead_t    head,
  input  logic                pop
);

  jfcs_pkg::cmd_t                   q [jfcs_pkg::Q_DEPTH];
  logic [jfcs_pkg::QPTR_W-1:0]      wr_ptr;
  logic [jfcs_pkg::QPTR_W-1:0]      rd_ptr;
  logic [jfcs_pkg::QCNT_W-1:0]      count;
  logic                             push;
  logic                             do_pop;
  jfcs_pkg::cmd_t                   cmd_in;

  assign in_ready = (count != jfcs_pkg::QCNT_W'(jfcs_pkg::Q_DEPTH));
  assign push     = in_valid && in_ready;
  assign do_pop   = pop && (count != '0);

  always_comb begin
    cmd_in.pc        = jfcs_pkg::start_pc(kind);
    cmd_in.data_byte = data_byte;
  end

  assign head.valid = (count != '0);
  assign head.cmd   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[src/jfcs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfcs_back
// Step engine: walks the step program for the queued item and issues one
// pulse run per cycle into the output register while it is free or taken.
// ----------------------------------------------------------------------------
module jfcs_back #(
  parameter int INSTR_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  jfcs_pkg::cfg_t                cfg,
  input  jfcs_pkg::qhead_t              head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          tms,
  output logic                          tdi,
  output logic [jfcs_pkg::CNT_W-1:0]    pulses,
  output logic                          release_res,
  output logic                          last
);

  // Shape of an instruction shift
  localparam int LOOP_BITS = (INSTR_BITS - 1 < jfcs_pkg::REG_BITS) ?
                             INSTR_BITS - 1 : jfcs_pkg::REG_BITS;
  localparam bit HAS_ZRUN  = (INSTR_BITS - 1 > jfcs_pkg::REG_BITS);
  localparam int ZRUN      = HAS_ZRUN ? INSTR_BITS - 1 - jfcs_pkg::REG_BITS : 1;
  localparam bit LAST_IN   = (INSTR_BITS - 1 < jfcs_pkg::REG_BITS);
  localparam int LAST_IDX  = LAST_IN ? INSTR_BITS - 1 : 0;
  localparam int SHIFT_END = HAS_ZRUN ? LOOP_BITS + 1 : LOOP_BITS;

  logic                              busy;
  logic [jfcs_pkg::PC_W-1:0]         pc;
  logic [jfcs_pkg::IDX_W-1:0]        idx;
  logic [7:0]                        byte_q;
  logic                              tdi_level;

  logic [jfcs_pkg::PC_W-1:0]         cur_pc;
  logic [7:0]                        cur_byte;
  jfcs_pkg::op_t                     op;
  logic [jfcs_pkg::REG_BITS-1:0]     instr;
  logic                              adv;
  logic                              step_done;
  logic                              r_tms;
  logic                              r_tdi;
  logic [jfcs_pkg::CNT_W-1:0]        r_pulses;
  logic                              r_rel;
  logic                              lvl_next;

  assign cur_pc   = busy ? pc : head.cmd.pc;
  assign cur_byte = busy ? byte_q : head.cmd.data_byte;
  assign op       = jfcs_pkg::rom_op(cur_pc);
  assign adv      = (busy || head.valid) && (!out_valid || out_ready);
  assign pop      = adv && !busy;

  always_comb begin
    case (op.sel)
      jfcs_pkg::SEL_PROGRAM: instr = cfg.program_instr;
      jfcs_pkg::SEL_STATUS:  instr = cfg.status_instr;
      default:               instr = cfg.startup_instr;
    endcase
  end

  always_comb begin
    r_tms     = op.tms;
    r_tdi     = tdi_level;
    r_pulses  = jfcs_pkg::CNT_W'(1);
    r_rel     = 1'b0;
    lvl_next  = tdi_level;
    step_done = 1'b1;
    case (op.code)
      jfcs_pkg::OP_PULSE: begin
      end
      jfcs_pkg::OP_PULSE_HI: begin
        r_tdi    = 1'b1;
        lvl_next = 1'b1;
      end
      jfcs_pkg::OP_SHIFT: begin
        step_done = (idx == jfcs_pkg::IDX_W'(SHIFT_END));
        if (idx < jfcs_pkg::IDX_W'(LOOP_BITS)) begin
          r_tms = 1'b0;
          r_tdi = instr[idx];
        end else if (HAS_ZRUN && idx == jfcs_pkg::IDX_W'(LOOP_BITS)) begin
          // upper instruction bits beyond the register read as zero
          r_tms    = 1'b0;
          r_tdi    = 1'b0;
          r_pulses = jfcs_pkg::CNT_W'(ZRUN);
        end else begin
          r_tms = 1'b1;
          r_tdi = LAST_IN ? instr[LAST_IDX] : 1'b0;
        end
        lvl_next = r_tdi;
      end
      jfcs_pkg::OP_DATA: begin
        step_done = (idx == jfcs_pkg::IDX_W'(7));
        r_tms     = 1'b0;
        r_tdi     = cur_byte[idx[2:0]];
        lvl_next  = r_tdi;
      end
      jfcs_pkg::OP_RUN_RESET: begin
        r_pulses = jfcs_pkg::CNT_W'(cfg.reset_clocks);
      end
      jfcs_pkg::OP_RUN_RESET_REL: begin
        // released TDI pin floats high
        r_pulses = jfcs_pkg::CNT_W'(cfg.reset_clocks);
        r_rel    = 1'b1;
        lvl_next = 1'b1;
      end
      jfcs_pkg::OP_RUN_PRELOAD: begin
        r_tdi    = 1'b1;
        r_pulses = cfg.preload_clocks;
        lvl_next = 1'b0;
      end
      jfcs_pkg::OP_RUN_ONES: begin
        r_tdi    = 1'b1;
        r_pulses = cfg.postamble_ones;
        lvl_next = 1'b1;
      end
      jfcs_pkg::OP_RUN_IDLE: begin
        r_pulses = cfg.idle_clocks;
      end
      default: begin
      end
    endcase
  end

  // Result register: payload needs no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      tms         <= r_tms;
      tdi         <= r_tdi;
      pulses      <= r_pulses;
      release_res <= r_rel;
      last        <= op.last && step_done;
    end
    if (pop) begin
      byte_q <= head.cmd.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pc        <= '0;
      idx       <= '0;
      tdi_level <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
        tdi_level <= lvl_next;
        if (step_done) begin
          idx  <= '0;
          pc   <= cur_pc + 1'b1;
          busy <= !op.last;
        end else begin
          idx  <= idx + 1'b1;
          pc   <= cur_pc;
          busy <= 1'b1;
        end
      end
    end
  end

endmodule

[src/jtag_fpga_config_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtag_fpga_config_sequencer
// JTAG script engine for bitstream loading: turns start, data, postamble and
// end items into runs of TCK pulses at fixed TMS and TDI levels.
// ----------------------------------------------------------------------------
// The step engine issues one pulse run per cycle while the output is taken;
// an item causes 8 results for a data byte, 2 for the postamble, 11 + S for
// start and 16 + 2*S for end, where S is min(INSTR_BITS, 11) plus one more
// when INSTR_BITS exceeds 11 (the zero run). These counts are set by the step
// engine walking its step program one result at a time; a two-entry item
// queue in front of it keeps input acceptance going while a result waits in
// the output register. Configuration writes take effect on the next cycle and
// are meant for idle periods.
// ----------------------------------------------------------------------------
module jtag_fpga_config_sequencer #(
  parameter int INSTR_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [jfcs_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [jfcs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         kind,
  input  logic [7:0]                         data_byte,
  input  logic                               chunk_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               tms,
  output logic                               tdi,
  output logic [jfcs_pkg::CNT_W-1:0]         pulses,
  output logic                               release_res,
  output logic                               last
);

  jfcs_pkg::cfg_t    cfg;
  jfcs_pkg::qhead_t  q_head;
  logic              q_pop;

  // chunk_end carries no pin effect; it is accepted and dropped

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.program_instr  <= jfcs_pkg::RST_PROGRAM_INSTR;
      cfg.status_instr   <= jfcs_pkg::RST_STATUS_INSTR;
      cfg.startup_instr  <= jfcs_pkg::RST_STARTUP_INSTR;
      cfg.preload_clocks <= jfcs_pkg::RST_PRELOAD_CLOCKS;
      cfg.idle_clocks    <= jfcs_pkg::RST_IDLE_CLOCKS;
      cfg.postamble_ones <= jfcs_pkg::RST_POSTAMBLE_ONES;
      cfg.reset_clocks   <= jfcs_pkg::RST_RESET_CLOCKS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        jfcs_pkg::REG_PROGRAM_INSTR:
          cfg.program_instr  <= cfg_wdata[jfcs_pkg::REG_BITS-1:0];
        jfcs_pkg::REG_STATUS_INSTR:
          cfg.status_instr   <= cfg_wdata[jfcs_pkg::REG_BITS-1:0];
        jfcs_pkg::REG_STARTUP_INSTR:
          cfg.startup_instr  <= cfg_wdata[jfcs_pkg::REG_BITS-1:0];
        jfcs_pkg::REG_PRELOAD_CLOCKS:
          cfg.preload_clocks <= cfg_wdata[jfcs_pkg::CNT_W-1:0];
        jfcs_pkg::REG_IDLE_CLOCKS:
          cfg.idle_clocks    <= cfg_wdata[jfcs_pkg::CNT_W-1:0];
        jfcs_pkg::REG_POSTAMBLE_ONES:
          cfg.postamble_ones <= cfg_wdata[jfcs_pkg::CNT_W-1:0];
        jfcs_pkg::REG_RESET_CLOCKS:
          cfg.reset_clocks   <= cfg_wdata[jfcs_pkg::RST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  jfcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .data_byte (data_byte),
    .head      (q_head),
    .pop       (q_pop)
  );

  jfcs_back #(
    .INSTR_BITS (INSTR_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (q_head),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .tms         (tms),
    .tdi         (tdi),
    .pulses      (pulses),
    .release_res (release_res),
    .last        (last)
  );

  a_release_is_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && release_res |-> last && tms)
    else $error("pin release on a result that is not the final TMS-high run");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_head.valid)
    else $error("step engine took an item from an empty queue");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid
      && $stable({tms, tdi, pulses, release_res, last}))
    else $error("waiting result dropped or changed");

endmodule

[sim/tb_jtag_fpga_config_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_jtag_fpga_config_sequencer
// Self-checking bench for the JTAG configuration sequencer. A table of script
// items covers reset values, zero and full-scale registers and steps taken
// outside a shift. Random script sequences and noise follow under random
// register settings. Each pin run is compared against an in-bench pin-run
// predictor, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb_jtag_fpga_config_sequencer;

  localparam int INSTR_W     = 10;
  localparam int DIR_ROWS    = 24;
  localparam int LONG_HOLD   = 300;
  localparam int STALL_LIMIT = 4000;

  typedef enum logic [1:0] {CFG_KEEP, CFG_ZERO, CFG_MAX, CFG_RANDOM} cfg_pick_t;

  typedef struct packed {
    logic                       tms;
    logic                       tdi;
    logic [jfcs_pkg::CNT_W-1:0] pulses;
    logic                       rel;
    logic                       last;
  } pin_run_t;

  typedef struct packed {
    cfg_pick_t                  cfg;
    logic [1:0]                 kind;
    logic [7:0]                 dbyte;
    logic                       chunk_end;
    logic                       typed;
    logic                       tms;
    logic                       tdi;
    logic [jfcs_pkg::CNT_W-1:0] pulses;
  } script_row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_wr_en = 1'b0;
  logic [jfcs_pkg::REG_IDX_W-1:0]  cfg_index = '0;
  logic [jfcs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [1:0]                      kind = jfcs_pkg::KIND_START;
  logic [7:0]                      data_byte = '0;
  logic                            chunk_end = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            tms;
  logic                            tdi;
  logic [jfcs_pkg::CNT_W-1:0]      pulses;
  logic                            release_res;
  logic                            last;

  // predictor state
  jfcs_pkg::cfg_t cfg_model;
  logic           held_tdi;
  pin_run_t       step_runs[$];
  pin_run_t       pin_runs_exp[$];
  pin_run_t       exp_run;

  script_row_t dir_rows [DIR_ROWS];

  int  n_errors = 0;
  int  stall_cycles = 0;
  int  items_sent = 0;
  int  burst_left = 1;
  int  gap_left = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  rx_mode = 0;
  int  mode_left = 0;

  jtag_fpga_config_sequencer #(.INSTR_BITS(INSTR_W)) dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .data_byte(data_byte), .chunk_end(chunk_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .tms(tms), .tdi(tdi), .pulses(pulses), .release_res(release_res), .last(last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void add_run(logic t, logic d, logic [jfcs_pkg::CNT_W-1:0] n,
                                  logic rel);
    pin_run_t r;
    r.tms    = t;
    r.tdi    = d;
    r.pulses = n;
    r.rel    = rel;
    r.last   = 1'b0;
    step_runs.push_back(r);
  endfunction

  function automatic void walk(logic t);
    add_run(t, held_tdi, jfcs_pkg::CNT_W'(1), 1'b0);
  endfunction

  // Leaves the TAP in Exit1-IR; bits past the register width go out as zeros
  function automatic void shift_ir(logic [jfcs_pkg::REG_BITS-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    for (int i = 0; i + 1 < INSTR_W && i < jfcs_pkg::REG_BITS; i++) begin
      held_tdi = wide[i];
      add_run(1'b0, held_tdi, jfcs_pkg::CNT_W'(1), 1'b0);
    end
    if (INSTR_W - 1 > jfcs_pkg::REG_BITS) begin
      held_tdi = 1'b0;
      add_run(1'b0, 1'b0, jfcs_pkg::CNT_W'(INSTR_W - 1 - jfcs_pkg::REG_BITS), 1'b0);
    end
    held_tdi = (INSTR_W - 1 < jfcs_pkg::REG_BITS) ? wide[INSTR_W - 1] : 1'b0;
    add_run(1'b1, held_tdi, jfcs_pkg::CNT_W'(1), 1'b0);
  endfunction

  function automatic void predict_step(logic [1:0] k, logic [7:0] b);
    step_runs.delete();
    case (k)
      jfcs_pkg::KIND_START: begin
        add_run(1'b1, held_tdi, jfcs_pkg::CNT_W'(cfg_model.reset_clocks), 1'b0);
        walk(1'b0); walk(1'b1); walk(1'b1); walk(1'b0); walk(1'b0);
        shift_ir(cfg_model.program_instr);
        walk(1'b1);
        held_tdi = 1'b1;
        walk(1'b1); walk(1'b0); walk(1'b0);
        add_run(1'b0, 1'b1, cfg_model.preload_clocks, 1'b0);
        held_tdi = 1'b0;
      end
      jfcs_pkg::KIND_DATA: begin
        for (int j = 0; j < 8; j++) begin
          held_tdi = b[j];
          add_run(1'b0, held_tdi, jfcs_pkg::CNT_W'(1), 1'b0);
        end
      end
      jfcs_pkg::KIND_POST: begin
        held_tdi = 1'b1;
        add_run(1'b0, 1'b1, cfg_model.postamble_ones, 1'b0);
        walk(1'b1);
      end
      default: begin
        walk(1'b1); walk(1'b0); walk(1'b0); walk(1'b1);
        walk(1'b1); walk(1'b0); walk(1'b0);
        shift_ir(cfg_model.status_instr);
        walk(1'b1); walk(1'b1); walk(1'b1); walk(1'b0); walk(1'b0);
        shift_ir(cfg_model.startup_instr);
        walk(1'b1); walk(1'b0);
        add_run(1'b0, held_tdi, cfg_model.idle_clocks, 1'b0);
        add_run(1'b1, held_tdi, jfcs_pkg::CNT_W'(cfg_model.reset_clocks), 1'b1);
        // released TDI pin is left high
        held_tdi = 1'b1;
      end
    endcase
    step_runs[step_runs.size() - 1].last = 1'b1;
  endfunction

  function automatic void set_model_reg(logic [jfcs_pkg::REG_IDX_W-1:0] idx,
                                        logic [jfcs_pkg::CFG_DATA_W-1:0] v);
    case (idx)
      jfcs_pkg::REG_PROGRAM_INSTR:  cfg_model.program_instr  = v[jfcs_pkg::REG_BITS-1:0];
      jfcs_pkg::REG_STATUS_INSTR:   cfg_model.status_instr   = v[jfcs_pkg::REG_BITS-1:0];
      jfcs_pkg::REG_STARTUP_INSTR:  cfg_model.startup_instr  = v[jfcs_pkg::REG_BITS-1:0];
      jfcs_pkg::REG_PRELOAD_CLOCKS: cfg_model.preload_clocks = v[jfcs_pkg::CNT_W-1:0];
      jfcs_pkg::REG_IDLE_CLOCKS:    cfg_model.idle_clocks    = v[jfcs_pkg::CNT_W-1:0];
      jfcs_pkg::REG_POSTAMBLE_ONES: cfg_model.postamble_ones = v[jfcs_pkg::CNT_W-1:0];
      jfcs_pkg::REG_RESET_CLOCKS:   cfg_model.reset_clocks   = v[jfcs_pkg::RST_W-1:0];
      default: ;
    endcase
  endfunction

  // ------------------------------------------------------------------ drivers
  task automatic send_item(input script_row_t row);
    while (gap_left > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      gap_left--;
    end
    @(negedge clk);
    in_valid  = 1'b1;
    kind      = row.kind;
    data_byte = row.dbyte;
    chunk_end = row.chunk_end;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_step(row.kind, row.dbyte);
    if (row.typed) begin
      step_runs[0].tms    = row.tms;
      step_runs[0].tdi    = row.tdi;
      step_runs[0].pulses = row.pulses;
    end
    foreach (step_runs[i]) pin_runs_exp.push_back(step_runs[i]);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
    end
  endtask

  task automatic send_random(input logic [1:0] k);
    script_row_t row;
    row           = '0;
    row.cfg       = CFG_KEEP;
    row.kind      = k;
    row.dbyte     = 8'($urandom_range(0, 255));
    row.chunk_end = 1'($urandom_range(0, 1));
    send_item(row);
  endtask

  // Stop offering items and wait until every pin run has come out
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pin_runs_exp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_config(input cfg_pick_t pick);
    logic [jfcs_pkg::CFG_DATA_W-1:0] v;
    for (int i = jfcs_pkg::REG_PROGRAM_INSTR; i <= jfcs_pkg::REG_RESET_CLOCKS; i++) begin
      case (pick)
        CFG_ZERO: v = '0;
        CFG_MAX:  v = '1;
        default:
          case ($urandom_range(0, 3))
            0:       v = '0;
            1:       v = '1;
            default: v = jfcs_pkg::CFG_DATA_W'($urandom_range(0,
                           (1 << jfcs_pkg::CFG_DATA_W) - 1));
          endcase
      endcase
      @(negedge clk);
      cfg_wr_en = 1'b1;
      cfg_index = jfcs_pkg::REG_IDX_W'(i);
      cfg_wdata = v;
      set_model_reg(jfcs_pkg::REG_IDX_W'(i), v);
    end
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Output side: randomly chosen stall patterns; a requested
  // long hold lets the item queue fill and back up the input
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD;
      out_ready = 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (rx_mode)
        0:       out_ready = 1'b1;
        1:       out_ready = 1'($urandom_range(0, 1));
        2:       out_ready = ($urandom_range(0, 3) != 0);
        default: out_ready = ((mode_left % 5) >= 2);
      endcase
    end
  end

  // ------------------------------------------------------------------ checker
  task automatic check_field(input string name, input logic [31:0] expv,
                             input logic [31:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (out_valid && out_ready) begin
        if (pin_runs_exp.size() == 0) begin
          $error("pin run with nothing pending: tms %0b tdi %0b pulses %0d",
                 tms, tdi, pulses);
          n_errors++;
        end else begin
          exp_run = pin_runs_exp.pop_front();
          check_field("tms", 32'(exp_run.tms), 32'(tms));
          check_field("tdi", 32'(exp_run.tdi), 32'(tdi));
          check_field("pulses", 32'(exp_run.pulses), 32'(pulses));
          check_field("release_res", 32'(exp_run.rel), 32'(release_res));
          check_field("last", 32'(exp_run.last), 32'(last));
        end
      end
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // -------------------------------------------------------------------- main
  initial begin
    int target;
    int n_bytes;

    cfg_model.program_instr  = jfcs_pkg::RST_PROGRAM_INSTR;
    cfg_model.status_instr   = jfcs_pkg::RST_STATUS_INSTR;
    cfg_model.startup_instr  = jfcs_pkg::RST_STARTUP_INSTR;
    cfg_model.preload_clocks = jfcs_pkg::RST_PRELOAD_CLOCKS;
    cfg_model.idle_clocks    = jfcs_pkg::RST_IDLE_CLOCKS;
    cfg_model.postamble_ones = jfcs_pkg::RST_POSTAMBLE_ONES;
    cfg_model.reset_clocks   = jfcs_pkg::RST_RESET_CLOCKS;
    held_tdi = 1'b0;

    // reset values, a full script, then steps outside a shift
    dir_rows[0]  = '{CFG_KEEP, jfcs_pkg::KIND_START, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 13'd10};
    dir_rows[1]  = '{CFG_KEEP, jfcs_pkg::KIND_DATA,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0};
    dir_rows[2]  = '{CFG_KEEP, jfcs_pkg::KIND_DATA,  8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0};
    dir_rows[3]  = '{CFG_KEEP, jfcs_pkg::KIND_DATA,  8'hA5, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0};
    dir_rows[4]  = '{CFG_KEEP, jfcs_pkg::KIND_DATA,  8'h5A, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0};
    dir_rows[5]  = '{CFG_KEEP, jfcs_pkg::KIND_POST,  8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 13'd127};
    dir_rows[6]  = '{CFG_KEEP, jfcs_pkg::KIND_END,   8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 13'd1};
    dir_rows[7]  = '{CFG_KEEP, jfcs_pkg::KIND_DATA,  8'h01, 1'b0, 1'b1, 1'b0, 1'b1, 13'd1};
    dir_rows[8]  = '{CFG_KEEP, jfcs_pkg::KIND_POST,  8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0};
    dir_rows[9]  = '{CFG_KEEP, jfcs_pkg::KIND_END,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0};
    dir_rows[10] = '{CFG_KEEP, jfcs_pkg::KIND_END,   8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0};
    dir_rows[11] = '{CFG_KEEP, jfcs_pkg::KIND_START, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0};
    dir_rows[12] = '{CFG_KEEP, jfcs_pkg::KIND_POST,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0};
    dir_rows[13] = '{CFG_KEEP, jfcs_pkg::KIND_DATA,  8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0};
    dir_rows[14] = '{CFG_KEEP, jfcs_pkg::KIND_START, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0};
    dir_rows[15] = '{CFG_KEEP, jfcs_pkg::KIND_END,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0};
    // zero counts and zero instructions
    dir_rows[16] = '{CFG_ZERO, jfcs_pkg::KIND_START, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 13'd0};
    dir_rows[17] = '{CFG_KEEP, jfcs_pkg::KIND_DATA,  8'h3C, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0};
    dir_rows[18] = '{CFG_KEEP, jfcs_pkg::KIND_POST,  8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 13'd0};
    dir_rows[19] = '{CFG_KEEP, jfcs_pkg::KIND_END,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0};
    // full-scale registers
    dir_rows[20] = '{CFG_MAX,  jfcs_pkg::KIND_START, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 13'd255};
    dir_rows[21] = '{CFG_KEEP, jfcs_pkg::KIND_DATA,  8'hC3, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0};
    dir_rows[22] = '{CFG_KEEP, jfcs_pkg::KIND_POST,  8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 13'd8191};
    dir_rows[23] = '{CFG_KEEP, jfcs_pkg::KIND_END,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].cfg != CFG_KEEP) begin
        settle();
        load_config(dir_rows[r].cfg);
      end
      send_item(dir_rows[r]);
    end

    // random phases: mostly whole scripts with random content, some noise
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      load_config(CFG_RANDOM);
      if (ph == 2) hold_req = 1'b1;
      target = items_sent + 22;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) < 8) begin
          send_random(jfcs_pkg::KIND_START);
          n_bytes = $urandom_range(1, 6);
          repeat (n_bytes) send_random(jfcs_pkg::KIND_DATA);
          send_random(jfcs_pkg::KIND_POST);
          send_random(jfcs_pkg::KIND_END);
        end else begin
          send_random(2'($urandom_range(0, 3)));
        end
      end
    end

    settle();
    repeat (40) @(posedge clk);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
